// ===== rtl/core/latpf_pkg.sv =====
// Package for the lidar azimuth and time point filter: payload types, constants, helpers.
package latpf_pkg;

	localparam int COORD_W = 20;
	localparam int TIME_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 40;

	// CORDIC datapath widths: coordinates scaled by 2^16 plus growth, angle in 2^-24 degree
	localparam int CORD_XW = COORD_W + 18;
	localparam int CORD_ZW = 34;
	localparam int YAW_W = 36;

	localparam int NEAR_X_MM = 100;

	localparam int DEF_YAW_FRAC_BITS = 8;
	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_WRAP_COOLDOWN = 1000;

	localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLIND_SQ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPIN_RATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_USE_POINT_TIME = 3'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_pos;
		logic signed [COORD_W-1:0] y_pos;
		logic signed [COORD_W-1:0] z_pos;
		logic signed [TIME_W-1:0] point_time;
		logic cloud_last;
	} in_t;

	typedef struct packed {
		logic kept;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic signed [TIME_W-1:0] out_time;
		logic cloud_end;
	} out_t;

	typedef struct packed {
		logic signed [CORD_XW-1:0] x;
		logic signed [CORD_XW-1:0] y;
		logic signed [CORD_ZW-1:0] z;
	} cordic_t;

	function automatic logic signed [CORD_ZW-1:0] atan_q24(input logic [4:0] i);
		logic signed [CORD_ZW-1:0] a;
		case (i)
			5'd0: a = 34'sd754974720;
			5'd1: a = 34'sd445687602;
			5'd2: a = 34'sd235489088;
			5'd3: a = 34'sd119537938;
			5'd4: a = 34'sd60000934;
			5'd5: a = 34'sd30029717;
			5'd6: a = 34'sd15018523;
			5'd7: a = 34'sd7509720;
			5'd8: a = 34'sd3754917;
			5'd9: a = 34'sd1877466;
			5'd10: a = 34'sd938734;
			5'd11: a = 34'sd469367;
			5'd12: a = 34'sd234684;
			5'd13: a = 34'sd117342;
			5'd14: a = 34'sd58671;
			5'd15: a = 34'sd29335;
			5'd16: a = 34'sd14668;
			5'd17: a = 34'sd7334;
			5'd18: a = 34'sd3667;
			5'd19: a = 34'sd1833;
			5'd20: a = 34'sd917;
			5'd21: a = 34'sd458;
			5'd22: a = 34'sd229;
			5'd23: a = 34'sd115;
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/latpf_cordic_cell.sv =====
// One vectoring step of the azimuth CORDIC, registered.
module latpf_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	input  latpf_pkg::cordic_t up,
	output logic dn_valid,
	output latpf_pkg::cordic_t dn
);
	import latpf_pkg::*;

	logic valid_q;
	cordic_t vec_q;
	cordic_t nxt;
	logic signed [CORD_XW-1:0] xs;
	logic signed [CORD_XW-1:0] ys;
	logic signed [CORD_ZW-1:0] ang;

	assign xs = up.x >>> STEP;
	assign ys = up.y >>> STEP;
	assign ang = atan_q24(5'(STEP));

	always_comb begin
		// rotate towards the x axis by the sign of y
		if (!up.y[CORD_XW-1]) begin
			nxt.x = up.x + ys;
			nxt.y = up.y - xs;
			nxt.z = up.z + ang;
		end else begin
			nxt.x = up.x - ys;
			nxt.y = up.y + xs;
			nxt.z = up.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= nxt;
	end

	assign dn_valid = valid_q;
	assign dn = vec_q;

endmodule

// ===== rtl/core/latpf_cordic_chain.sv =====
// Azimuth CORDIC: quadrant pre-rotation followed by a row of vectoring cells.
module latpf_cordic_chain #(
	parameter int CORDIC_STEPS = latpf_pkg::DEF_CORDIC_STEPS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [latpf_pkg::COORD_W-1:0] x_pos,
	input  logic signed [latpf_pkg::COORD_W-1:0] y_pos,
	output logic done,
	output logic signed [latpf_pkg::CORD_ZW-1:0] angle
);
	import latpf_pkg::*;

	logic signed [CORD_XW-1:0] xw;
	logic signed [CORD_XW-1:0] yw;
	cordic_t pre;
	cordic_t stage [0:CORDIC_STEPS];
	logic stage_valid [0:CORDIC_STEPS];
	logic pre_valid_q;
	cordic_t pre_q;

	assign xw = CORD_XW'(x_pos) <<< 16;
	assign yw = CORD_XW'(y_pos) <<< 16;

	always_comb begin
		// fold the left half plane into the right one by +-90 degrees
		if (xw[CORD_XW-1]) begin
			if (!yw[CORD_XW-1]) begin
				pre.x = yw;
				pre.y = -xw;
				pre.z = 34'sd1509949440;
			end else begin
				pre.x = -yw;
				pre.y = xw;
				pre.z = -34'sd1509949440;
			end
		end else begin
			pre.x = xw;
			pre.y = yw;
			pre.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_q <= 1'b0;
		end else begin
			pre_valid_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		pre_q <= pre;
	end

	assign stage[0] = pre_q;
	assign stage_valid[0] = pre_valid_q;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		latpf_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(stage_valid[i]),
			.up(stage[i]),
			.dn_valid(stage_valid[i+1]),
			.dn(stage[i+1])
		);
	end

	assign done = stage_valid[CORDIC_STEPS];
	assign angle = stage[CORDIC_STEPS].z;

endmodule

// ===== rtl/core/lidar_azimuth_time_point_filter_unit.sv =====
// Top level of the lidar azimuth and time point filter.
//
// Usage: one point enters on the in channel (in_valid / in_stall / in_data) and one result
// leaves on the out channel (out_valid / out_stall / out_data) for every point. Configuration
// is written through cfg_we / cfg_idx / cfg_data while no point is in flight.
// A point is worked on alone: the block stalls its input from acceptance until the result
// is moved to the output register once the output is free. A point passes the CORDIC row of
// cells and then, when it is far, outside the blind range and in azimuth mode, the unwrap
// and time multiply steps before the output step. The next point may be accepted in the
// very cycle after the result is moved, while the previous result still waits in the output
// register.
// If the receiver stalls, the result is held in the output register and the following
// point finishes its work and then waits in the final step until the register is free.
// Reset clears the in-cloud state (phase, first-point flag, yaws, bias, cooldown) and sets
// the registers to decimation 1, blind_sq 0, inv_spin_rate 1.0, time_limit 100000 and
// azimuth mode. A point flagged cloud_last clears the in-cloud state after its result.
module lidar_azimuth_time_point_filter_unit #(
	parameter int YAW_FRAC_BITS = latpf_pkg::DEF_YAW_FRAC_BITS,
	parameter int CORDIC_STEPS = latpf_pkg::DEF_CORDIC_STEPS,
	parameter int WRAP_COOLDOWN = latpf_pkg::DEF_WRAP_COOLDOWN
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  latpf_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output latpf_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [latpf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [latpf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import latpf_pkg::*;

	localparam int COOL_W = $clog2(WRAP_COOLDOWN + 1);
	localparam logic signed [YAW_W-1:0] HALF = YAW_W'(180 * (2 ** YAW_FRAC_BITS));
	localparam logic signed [YAW_W-1:0] FULL = YAW_W'(360 * (2 ** YAW_FRAC_BITS));
	localparam logic signed [CORD_ZW-1:0] ROUND = CORD_ZW'(2 ** (23 - YAW_FRAC_BITS));
	localparam int SQ_W = 2 * COORD_W;
	localparam int R2_W = SQ_W + 2;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CORD = 9'b000000010,
		S_Y1   = 9'b000000100,
		S_Y2   = 9'b000001000,
		S_Y3   = 9'b000010000,
		S_DIFF = 9'b000100000,
		S_MUL  = 9'b001000000,
		S_TIME = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0] dec_q;
	logic [39:0] blind_q;
	logic [31:0] inv_q;
	logic [30:0] tlim_q;
	logic stamped_q;

	// in-cloud state
	logic [7:0] phase_q;
	logic seen_q;
	logic signed [31:0] start_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] bias_q;
	logic [COOL_W-1:0] cool_q;

	// working registers
	in_t item_q;
	logic [SQ_W-1:0] sqx_q;
	logic [SQ_W-1:0] sqy_q;
	logic [SQ_W-1:0] sqz_q;
	logic blind_gt_q;
	logic blind_lt_q;
	logic signed [CORD_ZW-1:0] az_q;
	logic signed [YAW_W-1:0] yaw1_q;
	logic signed [YAW_W-1:0] yaw2_q;
	logic signed [YAW_W-1:0] yaw3_q;
	logic signed [31:0] dd_q;
	logic signed [64:0] prod_q;
	logic res_keep_q;
	logic signed [31:0] res_time_q;
	logic out_valid_q;
	out_t out_q;

	logic accept;
	logic cord_done;
	logic signed [CORD_ZW-1:0] cord_angle;
	logic signed [CORD_ZW-1:0] az_rnd;
	logic [R2_W-1:0] r2;
	logic far;
	logic on_phase;
	logic signed [YAW_W-1:0] yaw1;
	logic signed [YAW_W-1:0] d2;
	logic signed [YAW_W-1:0] bias_sum;
	logic signed [YAW_W-1:0] yaw3;
	logic signed [64:0] tsh;
	logic fin_go;
	logic [8:0] phase_inc;
	logic [8:0] dec_eff;
	logic [7:0] phase_nxt;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	latpf_cordic_chain #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.x_pos(in_data.x_pos),
		.y_pos(in_data.y_pos),
		.done(cord_done),
		.angle(cord_angle)
	);

	assign az_rnd = (cord_angle + ROUND) >>> (24 - YAW_FRAC_BITS);
	assign r2 = R2_W'(sqx_q) + R2_W'(sqy_q) + R2_W'(sqz_q);
	assign far = (item_q.x_pos >= COORD_W'(NEAR_X_MM)) || (item_q.x_pos <= -COORD_W'(NEAR_X_MM));
	assign on_phase = (phase_q == 8'd0);
	assign yaw1 = YAW_W'(az_q) - YAW_W'(bias_q);
	assign d2 = yaw1_q - YAW_W'(prev_q);
	assign bias_sum = YAW_W'(bias_q) + FULL;
	assign yaw3 = ((yaw2_q - YAW_W'(prev_q)) > HALF || (yaw2_q - YAW_W'(prev_q)) < -HALF) ?
		yaw2_q + FULL : yaw2_q;
	assign tsh = prod_q >>> 16;
	assign dec_eff = (dec_q == 8'd0) ? 9'd1 : {1'b0, dec_q};
	assign phase_inc = {1'b0, phase_q} + 9'd1;
	assign phase_nxt = (phase_inc >= dec_eff) ? 8'd0 : phase_inc[7:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= 8'd1;
			blind_q <= '0;
			inv_q <= 32'd65536;
			tlim_q <= 31'd100000;
			stamped_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DECIMATION: dec_q <= cfg_data[7:0];
				REG_BLIND_SQ: blind_q <= cfg_data[39:0];
				REG_INV_SPIN_RATE: inv_q <= cfg_data[31:0];
				REG_TIME_LIMIT: tlim_q <= cfg_data[30:0];
				REG_USE_POINT_TIME: stamped_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and in-cloud state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
			seen_q <= 1'b0;
			start_q <= '0;
			prev_q <= '0;
			bias_q <= '0;
			cool_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (cord_done) begin
						state_q <= S_Y1;
					end
				end
				S_Y1: begin
					if (stamped_q || !far) begin
						state_q <= S_FIN;
					end else begin
						// the first far point fixes the start yaw, blind or not
						if (!seen_q) begin
							start_q <= sat32(64'(yaw1));
							prev_q <= sat32(64'(yaw1));
							seen_q <= 1'b1;
						end
						state_q <= blind_lt_q ? S_FIN : S_Y2;
					end
				end
				S_Y2: begin
					if (d2 > HALF) begin
						if (cool_q == '0) begin
							bias_q <= (bias_sum > YAW_W'(32'sh7fffffff)) ?
								32'sh7fffffff : bias_sum[31:0];
							cool_q <= COOL_W'(WRAP_COOLDOWN);
						end else begin
							cool_q <= cool_q - COOL_W'(1);
						end
					end
					state_q <= S_Y3;
				end
				S_Y3: begin
					prev_q <= sat32(64'(yaw3));
					state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_MUL;
				S_MUL: state_q <= S_TIME;
				S_TIME: state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (item_q.cloud_last) begin
							phase_q <= '0;
							seen_q <= 1'b0;
							start_q <= '0;
							prev_q <= '0;
							bias_q <= '0;
							cool_q <= '0;
						end else begin
							phase_q <= phase_nxt;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			sqx_q <= SQ_W'(in_data.x_pos * in_data.x_pos);
			sqy_q <= SQ_W'(in_data.y_pos * in_data.y_pos);
			sqz_q <= SQ_W'(in_data.z_pos * in_data.z_pos);
		end
		if (state_q == S_CORD) begin
			blind_gt_q <= r2 > R2_W'(blind_q);
			blind_lt_q <= r2 < R2_W'(blind_q);
			az_q <= az_rnd;
		end
		case (state_q)
			S_Y1: begin
				yaw1_q <= yaw1;
				if (stamped_q) begin
					res_keep_q <= on_phase && blind_gt_q;
					res_time_q <= item_q.point_time;
				end else begin
					res_keep_q <= 1'b0;
					res_time_q <= '0;
				end
			end
			S_Y2: yaw2_q <= (d2 > HALF && cool_q == '0) ? yaw1_q - FULL : yaw1_q;
			S_Y3: yaw3_q <= yaw3;
			S_DIFF: dd_q <= sat32(64'(start_q) - 64'(yaw3_q));
			S_MUL: prod_q <= 65'(dd_q) * $signed({33'd0, inv_q});
			S_TIME: begin
				res_keep_q <= on_phase && !tsh[64] && (tsh < 65'(tlim_q));
				res_time_q <= sat32(tsh[63:0]);
			end
			default: ;
		endcase
		if (fin_go) begin
			out_q.kept <= res_keep_q;
			out_q.out_x <= item_q.x_pos;
			out_q.out_y <= item_q.y_pos;
			out_q.out_z <= item_q.z_pos;
			out_q.out_time <= res_time_q;
			out_q.cloud_end <= item_q.cloud_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// an item is only taken into an empty datapath
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CORD)
		else $error("item accepted while busy");

	// the CORDIC result arrives only while the sequencer waits for it
	a_cordic_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == S_CORD)
		else $error("CORDIC result outside its wait step");

	// a finished item always lands in the output register
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && state_q == S_IDLE)
		else $error("finished item not presented");

	// the cooldown never exceeds its reload value
	a_cool_range: assert property (@(posedge clk) disable iff (!arst_n)
		cool_q <= COOL_W'(WRAP_COOLDOWN))
		else $error("cooldown out of range");

	// the bias only grows from zero and saturates, so it never turns negative
	a_bias_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!bias_q[31])
		else $error("yaw bias negative");

endmodule
